>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the loudness meter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled at the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/pflm_pkg.sv
// Package of the loudness meter: widths, beat types, queue record and threshold table.
package pflm_pkg;

   // Field widths
   localparam int RAW_W       = 32;
   localparam int PCM_W       = 16;
   localparam int SHIFT_W     = 5;
   localparam int LEVEL_W     = 7;
   localparam int LEVEL_STEPS = 1 << LEVEL_W;

   // Frame limit and the accumulator widths that follow from it
   localparam int MAX_FRAME = 256;
   localparam int COUNT_W   = $clog2(MAX_FRAME + 1);
   localparam int SQ_W      = 2 * PCM_W - 1;
   localparam int SUM_W     = SQ_W + COUNT_W - 1;

   // Threshold search
   localparam int THR_W  = 41;
   localparam int PROD_W = COUNT_W + THR_W;
   localparam int BIT_W  = $clog2(LEVEL_W);

   // Front to back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SHIFT_W-1:0] RESET_SHIFT = SHIFT_W'(12);

   // Threshold law: T[k] = ceil(REF_POWER * 10^(k * DB_NUM / DB_DEN))
   localparam real REF_POWER_R = 400.0;
   localparam real DB_NUM_R    = 48.0;
   localparam real DB_DEN_R    = 635.0;

   typedef struct packed {
      logic signed [RAW_W-1:0] raw_word;
      logic                    last_sample;
   } req_type;

   typedef struct packed {
      logic signed [PCM_W-1:0] pcm_sample;
      logic                    saturated;
      logic                    level_valid;
      logic [LEVEL_W-1:0]      level;
   } rsp_type;

   // One accumulated sample on its way to the back end
   typedef struct packed {
      logic signed [PCM_W-1:0] pcm;
      logic                    sat;
      logic                    close;
      logic [SUM_W-1:0]        sum;
      logic [COUNT_W-1:0]      count;
   } rec_type;

   // Queue status seen by both ends
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_CMP,
      BK_DONE
   } back_state_type;

   typedef logic [LEVEL_STEPS-1:0][THR_W-1:0] thr_rom_type;

   // Build the threshold table at elaboration, rounding each entry up
   function automatic thr_rom_type build_thr_rom();
      thr_rom_type rom;
      real         r;
      longint      c;
      for (int k = 0; k < LEVEL_STEPS; k++) begin
         r = REF_POWER_R * (10.0 ** ((DB_NUM_R * real'(k)) / DB_DEN_R));
         c = longint'(r);
         if (real'(c) < r) begin
            c = c + 64'sd1;
         end
         rom[k] = THR_W'(c);
      end
      return rom;
   endfunction

   localparam thr_rom_type THR_ROM = build_thr_rom();

endpackage

>>> rtl/pflm_front.sv
// Front end: shift-amount register, scaling and saturation, squaring and frame accumulation.
module pflm_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [pflm_pkg::SHIFT_W-1:0] csr_write_data,
   input  logic                         req_push,
   output logic                         req_full,
   input  pflm_pkg::req_type            req_data,
   input  pflm_pkg::q_stat_type         q_stat,
   output logic                         q_push,
   output pflm_pkg::rec_type            q_data
);

   logic [pflm_pkg::SHIFT_W-1:0]  shift_ff;
   logic                          a_valid_ff, a_valid_in;
   logic signed [pflm_pkg::PCM_W-1:0] a_pcm_ff, a_pcm_in;
   logic                          a_sat_ff, a_sat_in;
   logic                          a_last_ff;
   logic [pflm_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [pflm_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic                          accept;
   logic                          advance;
   logic signed [pflm_pkg::RAW_W-1:0] shifted;
   logic signed [2*pflm_pkg::PCM_W-1:0] sq_full;
   logic [pflm_pkg::SUM_W-1:0]    sum_next;
   logic [pflm_pkg::COUNT_W-1:0]  count_next;
   logic                          close;

   // Take a word when the sample stage is free or drains this cycle
   assign advance  = a_valid_ff && !q_stat.full;
   assign req_full = a_valid_ff && q_stat.full;
   assign accept   = req_push && !req_full;

   // Shift and clamp the incoming word to 16 bits
   always_comb begin
      shifted  = req_data.raw_word >>> shift_ff;
      a_sat_in = !((&shifted[pflm_pkg::RAW_W-1:pflm_pkg::PCM_W-1]) ||
                   !(|shifted[pflm_pkg::RAW_W-1:pflm_pkg::PCM_W-1]));
      if (a_sat_in) begin
         a_pcm_in = shifted[pflm_pkg::RAW_W-1] ? {1'b1, {(pflm_pkg::PCM_W-1){1'b0}}}
                                               : {1'b0, {(pflm_pkg::PCM_W-1){1'b1}}};
      end else begin
         a_pcm_in = shifted[pflm_pkg::PCM_W-1:0];
      end
      a_valid_in = accept ? 1'b1 : (advance ? 1'b0 : a_valid_ff);
   end

   // Square the held sample and extend the open frame
   always_comb begin
      sq_full    = a_pcm_ff * a_pcm_ff;
      sum_next   = sum_ff + pflm_pkg::SUM_W'(sq_full[pflm_pkg::SQ_W-1:0]);
      count_next = count_ff + pflm_pkg::COUNT_W'(1);
      close      = a_last_ff || (count_next == pflm_pkg::COUNT_W'(pflm_pkg::MAX_FRAME));
      sum_in     = sum_ff;
      count_in   = count_ff;
      if (advance) begin
         sum_in   = close ? '0 : sum_next;
         count_in = close ? '0 : count_next;
      end
   end

   assign q_push       = advance;
   assign q_data.pcm   = a_pcm_ff;
   assign q_data.sat   = a_sat_ff;
   assign q_data.close = close;
   assign q_data.sum   = sum_next;
   assign q_data.count = count_next;

   // Control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff   <= pflm_pkg::RESET_SHIFT;
         a_valid_ff <= 1'b0;
         sum_ff     <= '0;
         count_ff   <= '0;
      end else begin
         if (csr_write_en) begin
            shift_ff <= csr_write_data;
         end
         a_valid_ff <= a_valid_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
      end
   end

   // Hold the accepted sample
   always_ff @(posedge clock) begin
      if (accept) begin
         a_pcm_ff  <= a_pcm_in;
         a_sat_ff  <= a_sat_in;
         a_last_ff <= req_data.last_sample;
      end
   end

endmodule

>>> rtl/pflm_queue.sv
// Short queue of accumulated samples between the front and back ends.
module pflm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pflm_pkg::rec_type    push_data,
   input  logic                 pop,
   output pflm_pkg::rec_type    pop_data,
   output pflm_pkg::q_stat_type stat
);

   pflm_pkg::rec_type             mem_ff [pflm_pkg::QUEUE_DEPTH];
   logic [pflm_pkg::QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [pflm_pkg::QCNT_W-1:0]   fill_ff, fill_in;
   logic                          do_push, do_pop;

   assign stat.full  = (fill_ff == pflm_pkg::QCNT_W'(pflm_pkg::QUEUE_DEPTH));
   assign stat.empty = (fill_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = mem_ff[rd_ptr_ff];

   // Track the fill level
   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + pflm_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - pflm_pkg::QCNT_W'(1);
      end
   end

   // Advance the pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + pflm_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + pflm_pkg::QPTR_W'(1);
         end
         fill_ff <= fill_in;
      end
   end

   // Store the incoming record
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/pflm_back.sv
// Back end: level search over the threshold table and the result register.
module pflm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  pflm_pkg::q_stat_type q_stat,
   input  pflm_pkg::rec_type    q_data,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output pflm_pkg::rsp_type    rsp_data
);

   pflm_pkg::back_state_type      state_ff, state_in;
   logic [pflm_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [pflm_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic signed [pflm_pkg::PCM_W-1:0] pcm_ff, pcm_in;
   logic                          sat_ff, sat_in;
   logic [pflm_pkg::LEVEL_W-1:0]  level_ff, level_in;
   logic [pflm_pkg::BIT_W-1:0]    bit_ff, bit_in;
   logic [pflm_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic                          out_valid_ff, out_valid_in;
   pflm_pkg::rsp_type             out_data_ff, out_data_in;

   logic                          slot_free;
   logic [pflm_pkg::LEVEL_W-1:0]  cand;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign cand      = level_ff | (pflm_pkg::LEVEL_W'(1) << bit_ff);
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Next state, search step and result load
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      pcm_in       = pcm_ff;
      sat_in       = sat_ff;
      level_in     = level_ff;
      bit_in       = bit_ff;
      prod_in      = prod_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_data_in  = out_data_ff;
      q_pop        = 1'b0;
      case (state_ff)
         pflm_pkg::BK_IDLE: begin
            if (!q_stat.empty && slot_free) begin
               q_pop = 1'b1;
               if (q_data.close) begin
                  sum_in   = q_data.sum;
                  count_in = q_data.count;
                  pcm_in   = q_data.pcm;
                  sat_in   = q_data.sat;
                  level_in = '0;
                  bit_in   = pflm_pkg::BIT_W'(pflm_pkg::LEVEL_W - 1);
                  state_in = pflm_pkg::BK_MUL;
               end else begin
                  out_valid_in            = 1'b1;
                  out_data_in.pcm_sample  = q_data.pcm;
                  out_data_in.saturated   = q_data.sat;
                  out_data_in.level_valid = 1'b0;
                  out_data_in.level       = '0;
               end
            end
         end
         pflm_pkg::BK_MUL: begin
            prod_in  = pflm_pkg::PROD_W'(count_ff) *
                       pflm_pkg::PROD_W'(pflm_pkg::THR_ROM[cand]);
            state_in = pflm_pkg::BK_CMP;
         end
         pflm_pkg::BK_CMP: begin
            if (pflm_pkg::PROD_W'(sum_ff) >= prod_ff) begin
               level_in = cand;
            end
            if (bit_ff == '0) begin
               state_in = pflm_pkg::BK_DONE;
            end else begin
               bit_in   = bit_ff - pflm_pkg::BIT_W'(1);
               state_in = pflm_pkg::BK_MUL;
            end
         end
         pflm_pkg::BK_DONE: begin
            if (slot_free) begin
               out_valid_in            = 1'b1;
               out_data_in.pcm_sample  = pcm_ff;
               out_data_in.saturated   = sat_ff;
               out_data_in.level_valid = 1'b1;
               out_data_in.level       = level_ff;
               state_in                = pflm_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = pflm_pkg::BK_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pflm_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Search operands and result payload
   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      count_ff    <= count_in;
      pcm_ff      <= pcm_in;
      sat_ff      <= sat_in;
      level_ff    <= level_in;
      bit_ff      <= bit_in;
      prod_ff     <= prod_in;
      out_data_ff <= out_data_in;
   end

endmodule

>>> rtl/pcm_frame_loudness_meter_core.sv
// Top level of the PCM frame loudness meter: front end, queue and back end.
//
//   channel   direction  handshake                  beat
//   req_      in         req_push / req_full        raw_word, last_sample
//   rsp_      out        rsp_pop / rsp_empty        pcm_sample, saturated, level_valid, level
//   csr_      in         csr_write_en               shift_amount (5 bits)
//
// The front end takes one word a cycle while req_full is low; a non-closing beat reaches the
// result side through the sample stage, the queue and the result register. A closing beat
// holds the back end for seven threshold multiply and compare steps, plus take and load.
// Reset is synchronous; it clears control state, the frame sum and count, and sets shift 12.
// A four-entry queue absorbs search cycles; req_full rises when it and the sample stage fill.
module pcm_frame_loudness_meter_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [pflm_pkg::SHIFT_W-1:0] csr_write_data,
   input  logic                         req_push,
   output logic                         req_full,
   input  pflm_pkg::req_type            req_data,
   input  logic                         rsp_pop,
   output logic                         rsp_empty,
   output pflm_pkg::rsp_type            rsp_data
);

   pflm_pkg::q_stat_type q_stat;
   pflm_pkg::rec_type    q_push_data;
   pflm_pkg::rec_type    q_pop_data;
   logic                 q_push;
   logic                 q_pop;

   pflm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .q_stat         (q_stat),
      .q_push         (q_push),
      .q_data         (q_push_data)
   );

   pflm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .stat      (q_stat)
   );

   pflm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/pflm_checker.sv
// Port-level checker of the loudness meter and its bind to the top level.
`include "assert_macros.svh"

module pflm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_push,
   input logic                         req_full,
   input logic                         rsp_pop,
   input logic                         rsp_empty,
   input pflm_pkg::rsp_type            rsp_data
);

   // Reset leaves no result waiting and the input side open
   `ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, rsp_empty && !req_full, "reset did not clear")

   // A waiting result that is not taken stays, unchanged
   `ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data), "result changed while stalled")

   // Back-pressure only builds after a beat was taken
   `ASSERT_NOW(a_full_cause, clock, reset, $rose(req_full), $past(req_push), "full rose without a push")

   // A beat that does not close a frame carries no level
   `ASSERT_NOW(a_level_idle, clock, reset, !rsp_empty && !rsp_data.level_valid, rsp_data.level == '0, "level set outside frame end")

endmodule

bind pcm_frame_loudness_meter_core pflm_checker u_checker (.*);

>>> test/tb_pcm_frame_loudness_meter_core.sv
// Self-checking testbench of the PCM frame loudness meter core.
`timescale 1ns / 1ps

module tb_pcm_frame_loudness_meter_core;

   localparam int          LEVEL_COUNT    = 128;
   localparam int          FRAME_LIMIT    = 256;
   localparam int          SETTLE_CYCLES  = 24;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam logic [4:0]  SHIFT_AT_RESET = 5'd12;

   typedef logic [127:0] fix_type;   // 32 integer bits, 96 fraction bits
   localparam fix_type FIX_ONE = 128'd1 << 96;

   typedef enum logic [1:0] {
      CMD_WORD,
      CMD_SHIFT,
      CMD_DRAIN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                 kind;
      pflm_pkg::req_type            word;
      logic [pflm_pkg::SHIFT_W-1:0] shift;
   } cmd_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_write_en = 1'b0;
   logic [pflm_pkg::SHIFT_W-1:0] csr_write_data = '0;
   logic                         req_push = 1'b0;
   logic                         req_full;
   pflm_pkg::req_type            req_data = '0;
   logic                         rsp_pop = 1'b0;
   logic                         rsp_empty;
   pflm_pkg::rsp_type            rsp_data;

   // Stimulus and expectations
   cmd_type                      source_cmds[$];
   pflm_pkg::rsp_type            expected_pcm_levels[$];
   int unsigned                  fail_count = 0;

   // Predictor state
   logic [63:0]                  level_threshold [LEVEL_COUNT];
   logic [pflm_pkg::SHIFT_W-1:0] meter_shift = SHIFT_AT_RESET;
   logic [63:0]                  frame_energy = '0;
   logic [63:0]                  frame_len = '0;

   // Driver and monitor working variables
   cmd_type                      head_cmd;
   logic                         push_next;
   logic                         wen_next;
   pflm_pkg::req_type            word_next;
   logic [pflm_pkg::SHIFT_W-1:0] shift_next;
   int unsigned                  gap_left = 0;
   int unsigned                  settle_cycles = 0;
   int unsigned                  stall_left = 0;
   pflm_pkg::rsp_type            want;
   logic                         steady = 1'b0;
   logic [7:0]                   steady_count = '0;
   int unsigned                  idle_cycles = 0;

   pcm_frame_loudness_meter_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_data       (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Fixed-point helpers for the threshold table
   function automatic fix_type fix_mul(fix_type a, fix_type b);
      logic [255:0] p;
      p = {128'd0, a} * {128'd0, b};
      return p[223:96];
   endfunction

   // atanh(1/m) by its series
   function automatic fix_type atanh_recip(int unsigned m);
      fix_type p;
      fix_type s;
      p = FIX_ONE / m;
      s = '0;
      for (int unsigned n = 1; p != 0 && n < 1000; n += 2) begin
         s = s + p / n;
         p = p / (m * m);
      end
      return s;
   endfunction

   function automatic fix_type fix_exp(fix_type x);
      fix_type s;
      fix_type t;
      s = FIX_ONE;
      t = FIX_ONE;
      for (int unsigned n = 1; n < 400 && t != 0; n++) begin
         t = fix_mul(t, x) / n;
         s = s + t;
      end
      return s;
   endfunction

   // T[k] = ceil(400 * 10^(48k/635)), built in 32.96 fixed point
   function automatic void build_level_thresholds();
      fix_type      ln10;
      fix_type      v;
      logic [191:0] prod;
      logic [63:0]  scale;
      int unsigned  e;
      int unsigned  ip;
      int unsigned  fr;
      ln10 = atanh_recip(3) * 6 + atanh_recip(9) * 2;
      for (int k = 0; k < LEVEL_COUNT; k++) begin
         e  = 48 * k;
         ip = e / 635;
         fr = e % 635;
         v  = fix_exp((ln10 * fr) / 635);
         scale = 64'd400;
         for (int unsigned i = 0; i < ip; i++) begin
            scale = scale * 10;
         end
         prod = {64'd0, v} * {128'd0, scale};
         level_threshold[k] = prod[159:96] + ((prod[95:0] != 0) ? 64'd1 : 64'd0);
      end
   endfunction

   // Shift, saturate, accumulate and close the frame where due
   function automatic pflm_pkg::rsp_type predict_pcm_level(pflm_pkg::req_type w);
      pflm_pkg::rsp_type  r;
      logic signed [31:0] shifted;
      logic signed [31:0] square;
      r = '0;
      shifted = $signed(w.raw_word) >>> meter_shift;
      if (shifted > 32'sd32767) begin
         r.pcm_sample = 16'sh7FFF;
         r.saturated  = 1'b1;
      end else if (shifted < -32'sd32768) begin
         r.pcm_sample = 16'sh8000;
         r.saturated  = 1'b1;
      end else begin
         r.pcm_sample = shifted[15:0];
      end
      square = $signed(r.pcm_sample) * $signed(r.pcm_sample);
      frame_energy = frame_energy + {32'd0, square};
      frame_len = frame_len + 1;
      if (w.last_sample || frame_len >= FRAME_LIMIT) begin
         r.level_valid = 1'b1;
         for (int k = 0; k < LEVEL_COUNT; k++) begin
            if (frame_energy >= frame_len * level_threshold[k]) begin
               r.level = 7'(k);
            end
         end
         frame_energy = '0;
         frame_len = '0;
      end
      return r;
   endfunction

   // Mostly short pauses, a few long ones, none in a steady stretch
   function automatic int unsigned pick_pause();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (steady || sel < 60) begin
         return 0;
      end else if (sel < 90) begin
         return $urandom_range(1, 3);
      end else if (sel < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic add_word(logic [31:0] raw, logic last);
      cmd_type c;
      c = '0;
      c.kind = CMD_WORD;
      c.word.raw_word = raw;
      c.word.last_sample = last;
      source_cmds.push_back(c);
   endtask

   task automatic add_cmd(cmd_kind_type kind, logic [pflm_pkg::SHIFT_W-1:0] shift);
      cmd_type c;
      c = '0;
      c.kind = kind;
      c.shift = shift;
      source_cmds.push_back(c);
   endtask

   // Toggle stretches with no idling on either side
   always @(posedge clock) begin
      if (steady_count == 8'd0) begin
         steady <= ($urandom_range(0, 3) == 0);
      end
      steady_count <= steady_count + 8'd1;
   end

   // Driver: present words, write the shift while idle, hold on drain
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         csr_write_en <= 1'b0;
         gap_left = 0;
         settle_cycles = 0;
      end else begin
         push_next  = req_push;
         wen_next   = 1'b0;
         word_next  = req_data;
         shift_next = csr_write_data;
         if (req_push && !req_full) begin
            expected_pcm_levels.push_back(predict_pcm_level(req_data));
            push_next = 1'b0;
         end
         if (expected_pcm_levels.size() == 0 && !req_push && !csr_write_en) begin
            settle_cycles++;
         end else begin
            settle_cycles = 0;
         end
         if (!push_next && gap_left > 0) begin
            gap_left--;
         end else if (!push_next && source_cmds.size() != 0) begin
            head_cmd = source_cmds[0];
            case (head_cmd.kind)
               CMD_WORD: begin
                  source_cmds.delete(0);
                  push_next = 1'b1;
                  word_next = head_cmd.word;
                  gap_left = pick_pause();
               end
               CMD_SHIFT: begin
                  if (settle_cycles >= SETTLE_CYCLES) begin
                     source_cmds.delete(0);
                     wen_next = 1'b1;
                     shift_next = head_cmd.shift;
                     meter_shift = head_cmd.shift;
                     settle_cycles = 0;
                  end
               end
               default: begin
                  if (settle_cycles >= SETTLE_CYCLES) begin
                     source_cmds.delete(0);
                  end
               end
            endcase
         end
         req_push <= push_next;
         req_data <= word_next;
         csr_write_en <= wen_next;
         csr_write_data <= shift_next;
      end
   end

   // Monitor: take result beats with random stalls and check each field
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_pcm_levels.size() == 0) begin
               $error("result beat with no expectation waiting: pcm_sample %0d",
                      $signed(rsp_data.pcm_sample));
               fail_count++;
            end else begin
               want = expected_pcm_levels.pop_front();
               if (rsp_data.pcm_sample !== want.pcm_sample) begin
                  $error("pcm_sample mismatch: expected %0d, actual %0d",
                         $signed(want.pcm_sample), $signed(rsp_data.pcm_sample));
                  fail_count++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated mismatch: expected %0d, actual %0d",
                         want.saturated, rsp_data.saturated);
                  fail_count++;
               end
               if (rsp_data.level_valid !== want.level_valid) begin
                  $error("level_valid mismatch: expected %0d, actual %0d",
                         want.level_valid, rsp_data.level_valid);
                  fail_count++;
               end
               if (rsp_data.level !== want.level) begin
                  $error("level mismatch: expected %0d, actual %0d",
                         want.level, rsp_data.level);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 25) begin
               stall_left = pick_pause();
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("pcm_frame_loudness_meter_core verification failed");
            $finish;
         end
      end
   end

   initial begin
      logic [pflm_pkg::SHIFT_W-1:0] phase_shift [10];
      int unsigned                  count;
      int unsigned                  len;
      int unsigned                  amp;
      int unsigned                  sel;

      build_level_thresholds();

      // Directed: saturation edges at the reset shift, quiet and loud frames
      add_word(32'h7FFF_FFFF, 1'b0);
      add_word(32'h8000_0000, 1'b0);
      add_word(32'h07FF_F000, 1'b0);
      add_word(32'h0800_0000, 1'b0);
      add_word(32'hF800_0000, 1'b0);
      add_word(32'hF7FF_FFFF, 1'b1);
      add_word(32'h0000_0000, 1'b1);
      add_word(32'hFFFF_FFFF, 1'b1);
      add_word(32'h0001_4000, 1'b1);
      add_word(32'h0001_3FFF, 1'b1);
      add_cmd(CMD_DRAIN, '0);
      // Shift extremes
      add_cmd(CMD_SHIFT, 5'd0);
      add_word(32'h0000_7FFF, 1'b0);
      add_word(32'h0000_8000, 1'b0);
      add_word(32'hFFFF_8000, 1'b0);
      add_word(32'hFFFF_7FFF, 1'b1);
      add_cmd(CMD_SHIFT, 5'd31);
      add_word(32'h7FFF_FFFF, 1'b0);
      add_word(32'h8000_0000, 1'b1);

      // Random phases, each under its own shift
      phase_shift = '{5'd16, 5'd0, 5'd31, 5'd8, 5'd0, 5'd0, 5'd4, 5'd20, 5'd12, 5'd0};
      phase_shift[4] = pflm_pkg::SHIFT_W'($urandom_range(0, 31));
      phase_shift[5] = pflm_pkg::SHIFT_W'($urandom_range(0, 31));
      phase_shift[9] = pflm_pkg::SHIFT_W'($urandom_range(0, 31));
      for (int p = 0; p < 10; p++) begin
         add_cmd(CMD_SHIFT, phase_shift[p]);
         // Open run that only the frame limit closes
         if (p == 1 || p == 6) begin
            amp = $urandom_range(0, 31);
            len = $urandom_range(256, 270);
            for (int unsigned i = 0; i < len; i++) begin
               add_word($signed($urandom()) >>> (31 - amp), 1'b0);
            end
         end
         count = 0;
         while (count < 45) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
               // Well-formed frame at one loudness, with an occasional full-range word
               amp = $urandom_range(0, 31);
               len = $urandom_range(1, 24);
               for (int unsigned i = 0; i < len; i++) begin
                  if ($urandom_range(0, 19) == 0) begin
                     add_word($urandom(), i == len - 1);
                  end else begin
                     add_word($signed($urandom()) >>> (31 - amp), i == len - 1);
                  end
               end
               count += len;
            end else if (sel < 94) begin
               // Noise: full-range words with random frame marks
               len = $urandom_range(1, 6);
               for (int unsigned i = 0; i < len; i++) begin
                  add_word($urandom(), 1'($urandom_range(0, 1)));
               end
               count += len;
            end else begin
               add_cmd(CMD_DRAIN, '0);
            end
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait for the stimulus to drain and every result to arrive
      while (source_cmds.size() != 0 || req_push || expected_pcm_levels.size() != 0) begin
         @(negedge clock);
      end
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("pcm_frame_loudness_meter_core verification clean");
      end else begin
         $display("pcm_frame_loudness_meter_core verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/pflm_pkg.sv
rtl/pflm_front.sv
rtl/pflm_queue.sv
rtl/pflm_back.sv
rtl/pcm_frame_loudness_meter_core.sv
rtl/pflm_checker.sv
test/tb_pcm_frame_loudness_meter_core.sv
